### rtl/tmg_pkg.sv
// Shared types, constants and helper functions for the torus mesh generator.
// No dependencies; used by torus_mesh_generator_unit.
`default_nettype none

package tmg_pkg;

	// segment counts and grid steps
	localparam int MAX_SEGMENTS = 256;
	localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int ROW_W        = SEG_W + 1;
	localparam int BASE_W       = $clog2(MAX_SEGMENTS * (MAX_SEGMENTS + 2) + 1);

	// sine table geometry
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int K_W              = $clog2(SINE_TABLE_DEPTH);
	localparam int QTR              = SINE_TABLE_DEPTH / 4;
	localparam int QTR_W            = K_W - 2;
	localparam int SIN_W            = 18;  // signed, magnitude up to 1.0 in Q16.16

	// ratio divider: Q = floor(p * 2^17 / n), one quotient bit per stage
	localparam int FRAC_W    = 16;
	localparam int QUO_W     = FRAC_W + 2;
	localparam int DIV_STEPS = FRAC_W + 1;
	localparam int TEX_W     = FRAC_W + 1;
	localparam int KSH       = FRAC_W - K_W;
	localparam int KH_W      = QUO_W - KSH;

	localparam logic [TEX_W-1:0] ONE_Q16 = TEX_W'(1 << FRAC_W);

	// configuration register indexes
	localparam logic [2:0] REG_CENTRE_X    = 3'd0;
	localparam logic [2:0] REG_CENTRE_Y    = 3'd1;
	localparam logic [2:0] REG_CENTRE_Z    = 3'd2;
	localparam logic [2:0] REG_RING_RADIUS = 3'd3;
	localparam logic [2:0] REG_TUBE_RADIUS = 3'd4;
	localparam logic [2:0] REG_RING_SEGS   = 3'd5;
	localparam logic [2:0] REG_TUBE_SEGS   = 3'd6;
	localparam logic [2:0] REG_ATTR_MASK   = 3'd7;

	// output word kinds
	localparam logic [4:0] KIND_POS_X  = 5'd0;
	localparam logic [4:0] KIND_POS_Y  = 5'd1;
	localparam logic [4:0] KIND_POS_Z  = 5'd2;
	localparam logic [4:0] KIND_TEX_U  = 5'd3;
	localparam logic [4:0] KIND_TEX_V  = 5'd4;
	localparam logic [4:0] KIND_NRM_X  = 5'd5;
	localparam logic [4:0] KIND_NRM_Y  = 5'd6;
	localparam logic [4:0] KIND_NRM_Z  = 5'd7;
	localparam logic [4:0] KIND_TAN_RX = 5'd8;
	localparam logic [4:0] KIND_TAN_RY = 5'd9;
	localparam logic [4:0] KIND_TAN_RZ = 5'd10;
	localparam logic [4:0] KIND_TAN_TX = 5'd11;
	localparam logic [4:0] KIND_TAN_TY = 5'd12;
	localparam logic [4:0] KIND_TAN_TZ = 5'd13;
	localparam logic [4:0] KIND_IDX_A  = 5'd14;
	localparam logic [4:0] KIND_IDX_C  = 5'd15;
	localparam logic [4:0] KIND_IDX_B  = 5'd16;
	localparam logic [4:0] KIND_IDX_D  = 5'd17;
	localparam logic [4:0] KIND_IDX_E  = 5'd18;
	localparam logic [4:0] KIND_IDX_F  = 5'd19;
	localparam logic [4:0] KIND_NONE   = 5'd20;
	localparam int         KIND_COUNT  = 20;

	typedef struct packed {
		logic [SEG_W-1:0] ring_step;
		logic [SEG_W-1:0] tube_step;
	} point_t;

	typedef struct packed {
		logic signed [31:0] word_value;
		logic [4:0]         word_kind;
		logic               last_word;
	} word_t;

	typedef logic [TEX_W-1:0] sin_tab_t [0:QTR];

	// signed product shifted by 30, rounded half away from zero
	function automatic longint mul_q30(longint a, longint b);
		logic        neg;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] m;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? 64'(-a) : 64'(a);
		mb  = (b < 0) ? 64'(-b) : 64'(b);
		m   = (ma * mb + 64'(1 << 29)) >> 30;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	// sin(pi/2 * x) for x = m / QTR, odd polynomial in Q30, result Q16.16
	function automatic longint quarter_sine(int m);
		longint x;
		longint x2;
		longint p;
		longint s;
		x  = longint'(m) <<< (30 - QTR_W);
		x2 = mul_q30(x, x);
		p  = -64'sd3864;
		p  = 64'sd172272 + mul_q30(p, x2);
		p  = -64'sd5026995 + mul_q30(p, x2);
		p  = 64'sd85569306 + mul_q30(p, x2);
		p  = -64'sd693598668 + mul_q30(p, x2);
		p  = 64'sd1686629713 + mul_q30(p, x2);
		s  = mul_q30(p, x);
		if (s < 0) begin
			s = 0;
		end else begin
			s = (s + 8192) >>> 14;
			if (s > 65536) begin
				s = 65536;
			end
		end
		return s;
	endfunction

	function automatic sin_tab_t sin_tab_build();
		sin_tab_t t;
		for (int m = 0; m <= QTR; m++) begin
			t[m] = TEX_W'(quarter_sine(m));
		end
		return t;
	endfunction

	localparam sin_tab_t SIN_TAB = sin_tab_build();

	// sine of table phase k, quarter-wave folded
	function automatic logic signed [SIN_W-1:0] sin_lookup(logic [K_W-1:0] k);
		logic [QTR_W:0]   m;
		logic [TEX_W-1:0] mag;
		m   = k[K_W-2] ? (QTR_W+1)'(QTR - int'(k[QTR_W-1:0]))
		               : {1'b0, k[QTR_W-1:0]};
		mag = SIN_TAB[m];
		return k[K_W-1] ? -$signed(SIN_W'(mag)) : $signed(SIN_W'(mag));
	endfunction

	// signed Q16.16 product, rounded half away from zero
	function automatic logic signed [34:0] mul_q16(logic signed [33:0] a,
	                                               logic signed [17:0] b);
		logic        neg;
		logic [33:0] ma;
		logic [17:0] mb;
		logic [51:0] pr;
		neg = a[33] ^ b[17];
		ma  = a[33] ? 34'(-a) : 34'(a);
		mb  = b[17] ? 18'(-b) : 18'(b);
		pr  = 52'(ma) * 52'(mb) + 52'(1 << 15);
		return neg ? -$signed({1'b0, pr[49:16]}) : $signed({1'b0, pr[49:16]});
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [35:0] v);
		if (v > 36'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -36'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

`default_nettype wire

### rtl/torus_mesh_generator_unit.sv
// Torus mesh generator: grid point in, stream of Q16.16 attribute and index words out.
// Depends on tmg_pkg (types, sine table, rounding products).
// An accepted point passes the 17-stage ratio divider and 8 arithmetic and output
// stages before its first word. Throughput: one word per cycle while word_ready is
// high; a point yields 3 to 20 words, and the output serializer loads the next point as the
// last word is taken. Reset empties the pipeline and loads register defaults.
`default_nettype none

module torus_mesh_generator_unit import tmg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [31:0] wr_data,
	input  wire logic        pt_valid,
	output logic             pt_ready,
	input  wire point_t      point,
	output logic             word_valid,
	input  wire logic        word_ready,
	output word_t            word
);

	typedef struct packed {
		logic [SEG_W-1:0] ring_idx;
		logic [SEG_W-1:0] tube_idx;
		logic [SEG_W-1:0] rem_r;
		logic [SEG_W-1:0] rem_t;
		logic [QUO_W-1:0] quo_r;
		logic [QUO_W-1:0] quo_t;
	} div_t;

	typedef struct packed {
		logic                    inner;
		logic [BASE_W-1:0]       base;
		logic [K_W-1:0]          k_r;
		logic [K_W-1:0]          k_t;
		logic [TEX_W-1:0]        tex_u;
		logic [TEX_W-1:0]        tex_v;
		logic signed [SIN_W-1:0] sm;
		logic signed [SIN_W-1:0] cm;
		logic signed [SIN_W-1:0] st;
		logic signed [SIN_W-1:0] ct;
		logic signed [31:0]      r_ct;
		logic signed [31:0]      r_st;
		logic signed [SIN_W-1:0] nx;
		logic signed [SIN_W-1:0] nz;
		logic signed [SIN_W-1:0] tx;
		logic signed [SIN_W-1:0] tz;
		logic signed [33:0]      rad;
		logic signed [31:0]      pos_y;
		logic signed [34:0]      px;
		logic signed [34:0]      pz;
		logic signed [31:0]      pos_x;
		logic signed [31:0]      pos_z;
	} geo_t;

	// configuration registers
	logic signed [31:0] centre_x_q, centre_y_q, centre_z_q;
	logic [30:0]        ring_radius_q, tube_radius_q;
	logic [SEG_W-1:0]   ring_segs_q, tube_segs_q;
	logic [2:0]         attr_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q    <= '0;
			centre_y_q    <= '0;
			centre_z_q    <= '0;
			ring_radius_q <= 31'd32768;
			tube_radius_q <= 31'd16384;
			ring_segs_q   <= SEG_W'(16);
			tube_segs_q   <= SEG_W'(16);
			attr_mask_q   <= 3'd3;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CENTRE_X:    centre_x_q    <= wr_data;
				REG_CENTRE_Y:    centre_y_q    <= wr_data;
				REG_CENTRE_Z:    centre_z_q    <= wr_data;
				REG_RING_RADIUS: ring_radius_q <= wr_data[30:0];
				REG_TUBE_RADIUS: tube_radius_q <= wr_data[30:0];
				REG_RING_SEGS:   ring_segs_q   <= wr_data[SEG_W-1:0];
				REG_TUBE_SEGS:   tube_segs_q   <= wr_data[SEG_W-1:0];
				REG_ATTR_MASK:   attr_mask_q   <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	// clamp segment counts to [1, MAX_SEGMENTS]
	logic [SEG_W-1:0] u_seg, v_seg;
	always_comb begin
		u_seg = ring_segs_q;
		if (ring_segs_q == '0) begin
			u_seg = SEG_W'(1);
		end else if (ring_segs_q > SEG_W'(MAX_SEGMENTS)) begin
			u_seg = SEG_W'(MAX_SEGMENTS);
		end
		v_seg = tube_segs_q;
		if (tube_segs_q == '0) begin
			v_seg = SEG_W'(1);
		end else if (tube_segs_q > SEG_W'(MAX_SEGMENTS)) begin
			v_seg = SEG_W'(MAX_SEGMENTS);
		end
	end

	// one restoring step: shift in a zero, subtract divisor when it fits
	function automatic div_t div_step(div_t d, logic [4:0] pos,
	                                  logic [SEG_W-1:0] nu, logic [SEG_W-1:0] nv);
		div_t           o;
		logic [SEG_W:0] sr;
		logic [SEG_W:0] st;
		o  = d;
		sr = {d.rem_r, 1'b0};
		st = {d.rem_t, 1'b0};
		if (sr >= {1'b0, nu}) begin
			sr         = sr - {1'b0, nu};
			o.quo_r[pos] = 1'b1;
		end
		if (st >= {1'b0, nv}) begin
			st         = st - {1'b0, nv};
			o.quo_t[pos] = 1'b1;
		end
		o.rem_r = sr[SEG_W-1:0];
		o.rem_t = st[SEG_W-1:0];
		return o;
	endfunction

	// next enabled word kind after k
	function automatic logic [4:0] kind_next(logic [4:0] k, logic [2:0] m, logic inn);
		logic [4:0] nk;
		nk = k + 5'd1;
		if (nk == KIND_TEX_U && !m[0]) nk = KIND_NRM_X;
		if (nk == KIND_NRM_X && !m[1]) nk = KIND_TAN_RX;
		if (nk == KIND_TAN_RX && !m[2]) nk = KIND_IDX_A;
		if (nk == KIND_IDX_A && !inn) nk = KIND_NONE;
		return nk;
	endfunction

	logic adv;

	// pipeline valid bits
	logic                 v_s1;
	logic [DIV_STEPS-1:0] v_s2;
	logic                 v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= '0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pt_valid;
			v_s2 <= {v_s2[DIV_STEPS-2:0], v_s1};
			v_s3 <= v_s2[DIV_STEPS-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// stage 1: clamp steps, integer part of the ratio
	div_t div_s1_d, div_s1;
	always_comb begin
		div_s1_d          = '0;
		div_s1_d.ring_idx = (point.ring_step > u_seg) ? u_seg : point.ring_step;
		div_s1_d.tube_idx = (point.tube_step > v_seg) ? v_seg : point.tube_step;
		if (div_s1_d.ring_idx == u_seg) begin
			div_s1_d.quo_r[QUO_W-1] = 1'b1;
		end else begin
			div_s1_d.rem_r = div_s1_d.ring_idx;
		end
		if (div_s1_d.tube_idx == v_seg) begin
			div_s1_d.quo_t[QUO_W-1] = 1'b1;
		end else begin
			div_s1_d.rem_t = div_s1_d.tube_idx;
		end
	end

	// stage 2: one fraction bit per divider stage
	div_t div_s2 [0:DIV_STEPS-1];
	geo_t geo_s3, geo_s4, geo_s5, geo_s6, geo_s7, geo_s8;
	geo_t geo_s3_d, geo_s4_d, geo_s5_d, geo_s6_d, geo_s7_d, geo_s8_d;

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s1    <= div_s1_d;
			div_s2[0] <= div_step(div_s1, 5'(DIV_STEPS - 1), u_seg, v_seg);
			for (int t = 1; t < DIV_STEPS; t++) begin
				div_s2[t] <= div_step(div_s2[t-1], 5'(DIV_STEPS - 1 - t), u_seg, v_seg);
			end
			geo_s3 <= geo_s3_d;
			geo_s4 <= geo_s4_d;
			geo_s5 <= geo_s5_d;
			geo_s6 <= geo_s6_d;
			geo_s7 <= geo_s7_d;
			geo_s8 <= geo_s8_d;
		end
	end

	// stage 3: round ratios into table phase and texcoords, vertex base
	always_comb begin
		logic [QUO_W:0]      tr, tt;
		logic [KH_W:0]       kr, kt;
		logic [SEG_W+ROW_W-1:0] bm;
		div_t                d;
		d        = div_s2[DIV_STEPS-1];
		geo_s3_d = '0;
		tr       = {1'b0, d.quo_r} + (QUO_W+1)'(1);
		tt       = {1'b0, d.quo_t} + (QUO_W+1)'(1);
		kr       = {1'b0, d.quo_r[QUO_W-1:KSH]} + (KH_W+1)'(1);
		kt       = {1'b0, d.quo_t[QUO_W-1:KSH]} + (KH_W+1)'(1);
		geo_s3_d.tex_u = ONE_Q16 - tr[TEX_W:1];
		geo_s3_d.tex_v = tt[TEX_W:1];
		geo_s3_d.k_r   = kr[K_W:1];
		geo_s3_d.k_t   = kt[K_W:1];
		geo_s3_d.inner = (d.ring_idx < u_seg) && (d.tube_idx < v_seg);
		bm             = d.ring_idx * ({1'b0, v_seg} + ROW_W'(1));
		geo_s3_d.base  = BASE_W'(bm) + BASE_W'(d.tube_idx);
	end

	// stage 4: sine table reads
	always_comb begin
		geo_s4_d    = geo_s3;
		geo_s4_d.sm = sin_lookup(geo_s3.k_r);
		geo_s4_d.cm = sin_lookup(geo_s3.k_r + K_W'(QTR));
		geo_s4_d.st = sin_lookup(geo_s3.k_t);
		geo_s4_d.ct = sin_lookup(geo_s3.k_t + K_W'(QTR));
	end

	// stage 5: tube offsets, normal and tangent products
	always_comb begin
		logic signed [33:0] rr;
		logic signed [34:0] p0, p1, p2, p3, p4, p5;
		rr            = $signed({3'b000, tube_radius_q});
		geo_s5_d      = geo_s4;
		p0            = mul_q16(rr, geo_s4.ct);
		p1            = mul_q16(rr, geo_s4.st);
		p2            = mul_q16(34'(geo_s4.cm), geo_s4.ct);
		p3            = mul_q16(34'(geo_s4.sm), geo_s4.ct);
		p4            = mul_q16(34'(geo_s4.st), geo_s4.cm);
		p5            = mul_q16(34'(geo_s4.st), geo_s4.sm);
		geo_s5_d.r_ct = p0[31:0];
		geo_s5_d.r_st = p1[31:0];
		geo_s5_d.nx   = p2[SIN_W-1:0];
		geo_s5_d.nz   = p3[SIN_W-1:0];
		geo_s5_d.tx   = -p4[SIN_W-1:0];
		geo_s5_d.tz   = -p5[SIN_W-1:0];
	end

	// stage 6: ring distance, position y
	always_comb begin
		geo_s6_d       = geo_s5;
		geo_s6_d.rad   = $signed({3'b000, ring_radius_q}) + 34'(geo_s5.r_ct);
		geo_s6_d.pos_y = sat32(36'(geo_s5.r_st) + 36'(centre_y_q));
	end

	// stage 7: ring products
	always_comb begin
		geo_s7_d    = geo_s6;
		geo_s7_d.px = mul_q16(geo_s6.rad, geo_s6.cm);
		geo_s7_d.pz = mul_q16(geo_s6.rad, geo_s6.sm);
	end

	// stage 8: centre offset with saturation
	always_comb begin
		geo_s8_d       = geo_s7;
		geo_s8_d.pos_x = sat32(36'(geo_s7.px) + 36'(centre_x_q));
		geo_s8_d.pos_z = sat32(36'(geo_s7.pz) + 36'(centre_z_q));
	end

	// word list of the finished point, by kind
	logic [31:0] words [0:KIND_COUNT-1];
	always_comb begin
		logic [31:0] b;
		logic [31:0] row;
		b   = 32'(geo_s8.base);
		row = 32'(v_seg) + 32'd1;
		words[KIND_POS_X]  = geo_s8.pos_x;
		words[KIND_POS_Y]  = geo_s8.pos_y;
		words[KIND_POS_Z]  = geo_s8.pos_z;
		words[KIND_TEX_U]  = 32'(geo_s8.tex_u);
		words[KIND_TEX_V]  = 32'(geo_s8.tex_v);
		words[KIND_NRM_X]  = 32'(geo_s8.nx);
		words[KIND_NRM_Y]  = 32'(geo_s8.st);
		words[KIND_NRM_Z]  = 32'(geo_s8.nz);
		words[KIND_TAN_RX] = 32'(-geo_s8.sm);
		words[KIND_TAN_RY] = '0;
		words[KIND_TAN_RZ] = 32'(geo_s8.cm);
		words[KIND_TAN_TX] = 32'(geo_s8.tx);
		words[KIND_TAN_TY] = 32'(geo_s8.ct);
		words[KIND_TAN_TZ] = 32'(geo_s8.tz);
		words[KIND_IDX_A]  = b;
		words[KIND_IDX_C]  = b + 32'd1;
		words[KIND_IDX_B]  = b + row;
		words[KIND_IDX_D]  = b + row;
		words[KIND_IDX_E]  = b + 32'd1;
		words[KIND_IDX_F]  = b + row + 32'd1;
	end

	// output serializer: hold one point's words, step through enabled kinds
	logic        hold_q;
	logic        inner_q;
	logic [4:0]  kind_q;
	logic [31:0] word_q [0:KIND_COUNT-1];
	logic [4:0]  kind_nx;
	logic        last_beat, take, load;

	assign kind_nx   = kind_next(kind_q, attr_mask_q, inner_q);
	assign last_beat = (kind_nx == KIND_NONE);
	assign take      = hold_q && word_ready && last_beat;
	assign load      = v_s8 && (!hold_q || take);
	assign adv       = !v_s8 || load;
	assign pt_ready  = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			kind_q <= KIND_POS_X;
		end else if (load) begin
			hold_q <= 1'b1;
			kind_q <= KIND_POS_X;
		end else if (take) begin
			hold_q <= 1'b0;
		end else if (hold_q && word_ready) begin
			kind_q <= kind_nx;
		end
	end

	// capture the point's words on load
	always_ff @(posedge clk) begin
		if (load) begin
			inner_q <= geo_s8.inner;
			for (int w = 0; w < KIND_COUNT; w++) begin
				word_q[w] <= words[w];
			end
		end
	end

	assign word_valid      = hold_q;
	assign word.word_value = word_q[kind_q];
	assign word.word_kind  = kind_q;
	assign word.last_word  = last_beat;

endmodule

`default_nettype wire

### dv/testbench.sv
// Testbench for torus_mesh_generator_unit: directed table then random grid points,
// every output word checked against an in-bench torus predictor. Depends on tmg_pkg.
`timescale 1ns / 100ps

module testbench;
	import tmg_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [31:0] wr_data;
	logic        pt_valid;
	logic        pt_ready;
	point_t      point;
	logic        word_valid;
	logic        word_ready;
	word_t       word;

	torus_mesh_generator_unit dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .pt_valid(pt_valid), .pt_ready(pt_ready),
		.point(point), .word_valid(word_valid), .word_ready(word_ready),
		.word(word)
	);

	// predictor copy of the registers
	longint cfg_cx, cfg_cy, cfg_cz, cfg_rr, cfg_tr;
	int     cfg_u, cfg_v, cfg_mask;

	word_t  expected_words[$];
	int     mismatches;
	int     words_seen;
	int     points_sent;
	int     send_idle_pct;
	int     recv_idle_pct;
	bit     hold_recv;
	int     quiet_cycles;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		int     ri;
		int     ti;
		bit     typed;
		longint x0;
	} stim_row_t;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic longint rmul(longint a, longint b, int sh);
		bit          neg;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] m;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? 64'(-a) : 64'(a);
		mb  = (b < 0) ? 64'(-b) : 64'(b);
		m   = (ma * mb + (64'd1 << (sh - 1))) >> sh;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint poly_sine(longint x);
		longint x2;
		longint p;
		longint s;
		x2 = rmul(x, x, 30);
		p  = -3864;
		p  = 172272 + rmul(p, x2, 30);
		p  = -5026995 + rmul(p, x2, 30);
		p  = 85569306 + rmul(p, x2, 30);
		p  = -693598668 + rmul(p, x2, 30);
		p  = 1686629713 + rmul(p, x2, 30);
		s  = rmul(p, x, 30);
		if (s < 0) begin
			return 0;
		end
		s = (s + 8192) >>> 14;
		return (s > 65536) ? 65536 : s;
	endfunction

	function automatic longint turn_sine(logic [31:0] t);
		logic [1:0] q;
		longint     r;
		longint     s;
		q = t[31:30];
		r = longint'(t[29:0]);
		s = poly_sine(q[0] ? 64'sd1073741824 - r : r);
		return q[1] ? -s : s;
	endfunction

	function automatic logic [31:0] grid_angle(longint p, longint n);
		longint k;
		k = ((p * SINE_TABLE_DEPTH + n / 2) / n) % SINE_TABLE_DEPTH;
		return 32'((k << 32) / SINE_TABLE_DEPTH);
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// append one word to the pending list
	task automatic push_word(longint v, logic [4:0] k);
		word_t w;
		w.word_value = 32'(v);
		w.word_kind  = k;
		w.last_word  = 1'b0;
		expected_words.insert(expected_words.size(), w);
	endtask

	// compute every word one grid point causes
	task automatic predict_point(int ri, int ti);
		longint u, v, i, j, sm, cm, st, ct, rad, base, row;
		logic [31:0] am, at;
		u = (cfg_u < 1) ? 1 : (cfg_u > MAX_SEGMENTS ? MAX_SEGMENTS : cfg_u);
		v = (cfg_v < 1) ? 1 : (cfg_v > MAX_SEGMENTS ? MAX_SEGMENTS : cfg_v);
		i = (ri > u) ? u : ri;
		j = (ti > v) ? v : ti;
		am = grid_angle(i, u);
		at = grid_angle(j, v);
		sm = turn_sine(am);
		cm = turn_sine(am + 32'h40000000);
		st = turn_sine(at);
		ct = turn_sine(at + 32'h40000000);
		rad = cfg_rr + rmul(cfg_tr, ct, 16);
		push_word(clip32(rmul(rad, cm, 16) + cfg_cx), KIND_POS_X);
		push_word(clip32(rmul(cfg_tr, st, 16) + cfg_cy), KIND_POS_Y);
		push_word(clip32(rmul(rad, sm, 16) + cfg_cz), KIND_POS_Z);
		if (cfg_mask[0]) begin
			push_word(65536 - (i * 65536 + u / 2) / u, KIND_TEX_U);
			push_word((j * 65536 + v / 2) / v, KIND_TEX_V);
		end
		if (cfg_mask[1]) begin
			push_word(rmul(cm, ct, 16), KIND_NRM_X);
			push_word(st, KIND_NRM_Y);
			push_word(rmul(sm, ct, 16), KIND_NRM_Z);
		end
		if (cfg_mask[2]) begin
			push_word(-sm, KIND_TAN_RX);
			push_word(0, KIND_TAN_RY);
			push_word(cm, KIND_TAN_RZ);
			push_word(-rmul(st, cm, 16), KIND_TAN_TX);
			push_word(ct, KIND_TAN_TY);
			push_word(-rmul(st, sm, 16), KIND_TAN_TZ);
		end
		if (i < u && j < v) begin
			row  = v + 1;
			base = i * row + j;
			push_word(base, KIND_IDX_A);
			push_word(base + 1, KIND_IDX_C);
			push_word(base + row, KIND_IDX_B);
			push_word(base + row, KIND_IDX_D);
			push_word(base + 1, KIND_IDX_E);
			push_word(base + row + 1, KIND_IDX_F);
		end
		expected_words[$].last_word = 1'b1;
	endtask

	task automatic report_mismatch(string what, word_t got, word_t want);
		mismatches++;
		$display("MISMATCH %s: got v=%0d k=%0d l=%0d want v=%0d k=%0d l=%0d", what,
			got.word_value, got.word_kind, got.last_word,
			want.word_value, want.word_kind, want.last_word);
	endtask

	// check each accepted beat against the oldest expectation
	always @(posedge clk) begin
		word_t want;
		if (arst_n && word_valid && word_ready) begin
			words_seen++;
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected beat", word, word);
			end else begin
				want = expected_words.pop_front();
				if (word.word_value !== want.word_value)
					report_mismatch("word_value", word, want);
				if (word.word_kind !== want.word_kind)
					report_mismatch("word_kind", word, want);
				if (word.last_word !== want.last_word)
					report_mismatch("last_word", word, want);
			end
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (!arst_n) begin
			word_ready <= 1'b0;
		end else if (hold_recv) begin
			word_ready <= 1'b0;
		end else begin
			word_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((pt_valid && pt_ready) || (word_valid && word_ready) || wr_en || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_CENTRE_X:    cfg_cx = longint'($signed(val));
			REG_CENTRE_Y:    cfg_cy = longint'($signed(val));
			REG_CENTRE_Z:    cfg_cz = longint'($signed(val));
			REG_RING_RADIUS: cfg_rr = longint'(val[30:0]);
			REG_TUBE_RADIUS: cfg_tr = longint'(val[30:0]);
			REG_RING_SEGS:   cfg_u = int'(val[8:0]);
			REG_TUBE_SEGS:   cfg_v = int'(val[8:0]);
			default:         cfg_mask = int'(val[2:0]);
		endcase
	endtask

	// drop valid, then let the pipeline drain before touching registers
	task automatic drain;
		@(negedge clk);
		pt_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// offer one point, idle first at random, hold until accepted
	task automatic send_point(int ri, int ti);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			pt_valid <= 1'b0;
			@(negedge clk);
		end
		pt_valid <= 1'b1;
		point.ring_step <= SEG_W'(ri);
		point.tube_step <= SEG_W'(ti);
		predict_point(ri, ti);
		@(posedge clk);
		while (!pt_ready) @(posedge clk);
		points_sent++;
	endtask

	task automatic random_config;
		write_reg(REG_CENTRE_X, $urandom_range(3) == 0 ? $urandom : $urandom_range(400000) - 200000);
		write_reg(REG_CENTRE_Y, $urandom_range(3) == 0 ? $urandom : $urandom_range(400000) - 200000);
		write_reg(REG_CENTRE_Z, $urandom_range(3) == 0 ? $urandom : $urandom_range(400000) - 200000);
		write_reg(REG_RING_RADIUS, $urandom_range(3) == 0 ? $urandom : $urandom_range(300000));
		write_reg(REG_TUBE_RADIUS, $urandom_range(3) == 0 ? $urandom : $urandom_range(150000));
		write_reg(REG_RING_SEGS, $urandom_range(7) == 0 ? $urandom_range(511) : $urandom_range(1, 24));
		write_reg(REG_TUBE_SEGS, $urandom_range(7) == 0 ? $urandom_range(511) : $urandom_range(1, 24));
		write_reg(REG_ATTR_MASK, $urandom_range(7));
	endtask

	stim_row_t dir_rows[$];

	initial begin
		int n, ri, ti;
		stim_row_t row;
		word_t typed_w;
		arst_n = 1'b0; wr_en = 1'b0; wr_index = '0; wr_data = '0;
		pt_valid = 1'b0; point = '0; hold_recv = 1'b0;
		mismatches = 0; words_seen = 0; points_sent = 0; quiet_cycles = 0;
		send_idle_pct = 26; recv_idle_pct = 85;
		cfg_cx = 0; cfg_cy = 0; cfg_cz = 0; cfg_rr = 32768; cfg_tr = 16384;
		cfg_u = 16; cfg_v = 16; cfg_mask = 3;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset defaults, corner x position typed in (0.75 at step 0)
		dir_rows = '{'{0, 0, 1, 49152}, '{16, 16, 0, 0}, '{4, 8, 0, 0},
			'{300, 2, 0, 0}, '{3, 511, 0, 0}, '{15, 15, 0, 0}, '{8, 0, 0, 0}};
		foreach (dir_rows[r]) begin
			row = dir_rows[r];
			send_point(row.ri, row.ti);
			if (row.typed && expected_words[0].word_value != 32'(row.x0)) begin
				typed_w            = expected_words[0];
				typed_w.word_value = 32'(row.x0);
				report_mismatch("typed row", expected_words[0], typed_w);
			end
		end
		drain();
		// extremes: every attribute, saturating position, one segment, zero segments
		write_reg(REG_ATTR_MASK, 7);
		write_reg(REG_CENTRE_X, 32'h7fffffff);
		write_reg(REG_CENTRE_Y, 32'h80000000);
		write_reg(REG_CENTRE_Z, 32'h80000000);
		write_reg(REG_RING_RADIUS, 32'h7fffffff);
		write_reg(REG_TUBE_RADIUS, 32'h7fffffff);
		write_reg(REG_RING_SEGS, 1);
		write_reg(REG_TUBE_SEGS, 0);
		send_point(0, 0); send_point(1, 1); send_point(511, 511); send_point(256, 0);
		drain();
		write_reg(REG_RING_SEGS, 256);
		write_reg(REG_TUBE_SEGS, 511);
		write_reg(REG_ATTR_MASK, 0);
		write_reg(REG_CENTRE_X, 0);
		send_point(255, 255); send_point(256, 256); send_point(128, 64);
		send_point(0, 255); send_point(170, 85);
		drain();

		// random phases with shifting idle profiles
		for (int ph = 0; ph < 12; ph++) begin
			random_config();
			if (ph < 4) begin send_idle_pct = 26; recv_idle_pct = 85; end
			else if (ph < 8) begin send_idle_pct = 85; recv_idle_pct = 26; end
			else begin send_idle_pct = 0; recv_idle_pct = 0; end
			if (ph == 9) begin
				fork
					begin
						hold_recv = 1'b1;
						for (int c = 0; c < 400; c++) @(posedge clk);
						hold_recv = 1'b0;
					end
				join_none
			end
			n = 35;
			for (int k = 0; k < n; k++) begin
				ri = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(cfg_u + 1);
				ti = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(cfg_v + 1);
				send_point(ri, ti);
			end
			drain();
		end

		$display("covered %0d points and %0d words across directed and 12 random settings",
			points_sent, words_seen);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
